FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL of the mailbox block.
// Each helper is defined twice: checking bodies for simulation, and empty
// bodies when the code is built for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define MTM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("mailbox assertion failed");

`define MTM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("mailbox assertion failed");

`else

`define MTM_ASSERT(lbl, prop)

`define MTM_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

FILE: rtl/core/mtm_pkg.sv
`timescale 1ns / 1ps

package mtm_pkg;

  localparam int unsigned RANKS_DEF = 16;
  localparam int unsigned SLOTS_DEF = 16;

  localparam logic [4:0] RANK_COUNT_RESET = 5'd16;

  typedef enum logic [2:0] {
    STATUS_QUEUED   = 3'd0,
    STATUS_MATCHED  = 3'd1,
    STATUS_NO_MATCH = 3'd2,
    STATUS_RANGE    = 3'd3,
    STATUS_FULL     = 3'd4
  } status_e;

  typedef enum logic {
    MODE_SEND    = 1'b0,
    MODE_RECEIVE = 1'b1
  } mode_e;

  typedef struct packed {
    logic [3:0]  src;
    logic [15:0] tag;
    logic [15:0] len;
    logic [15:0] handle;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

  typedef struct packed {
    status_e     status;
    logic [3:0]  src;
    logic [15:0] tag;
    logic [15:0] len;
    logic [15:0] copy;
    logic [15:0] handle;
  } result_t;

endpackage

FILE: rtl/core/mtm_ram.sv
`timescale 1ns / 1ps

module mtm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/message_tag_match_mailbox_top.sv
// Send request: it passes the check, fill and done states, and its result then enters
// the output register. Receive request: the scan reads the stored descriptors of that rank
// one at a time through the single read port of the descriptor memory.
// A rank out of range goes from the check state to done. One request is in work at a
// time; the next is accepted the cycle after the finished result enters the output register.
// Reset (rst_ni, asynchronous, active low) empties every mailbox at once.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module message_tag_match_mailbox_top #(
  parameter int unsigned RANKS = mtm_pkg::RANKS_DEF,
  parameter int unsigned SLOTS = mtm_pkg::SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [3:0]  rank_i,
  input  logic [3:0]  source_rank_i,
  input  logic        any_source_i,
  input  logic [15:0] msg_tag_i,
  input  logic        any_tag_i,
  input  logic [15:0] length_i,
  input  logic [15:0] payload_handle_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_code_o,
  output logic [3:0]  msg_source_o,
  output logic [15:0] msg_tag_out_o,
  output logic [15:0] msg_length_o,
  output logic [15:0] copy_length_o,
  output logic [15:0] payload_out_o
);

  localparam int unsigned RW = (RANKS > 1) ? $clog2(RANKS) : 1;
  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned FW = $clog2(SLOTS + 1);
  localparam int unsigned SLOT_DEPTH = 1 << (RW + SW);
  localparam int unsigned FILL_DEPTH = 1 << RW;
  localparam logic [6:0] RanksW = 7'(RANKS);
  localparam logic [FW-1:0] SlotsW = FW'(SLOTS);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CHK  = 3'd1;
  localparam logic [2:0] ST_FILL = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0] state_q, state_d;
  logic [4:0] rank_count_q;

  logic          mode_q;
  logic [3:0]    rank_q;
  logic [RW-1:0] rank_idx_q;
  logic [3:0]    src_q;
  logic          any_src_q;
  logic [15:0]   tag_q;
  logic          any_tag_q;
  logic [15:0]   len_q;
  logic [15:0]   handle_q;
  logic [RW+3:0] rank_ext;

  logic [FW-1:0] fill_q, fill_d;
  logic [FW-1:0] rd_idx_q, rd_idx_d;
  logic [SW-1:0] dk_q, dk_d;
  logic          dv_q, dv_d;
  logic          found_q, found_d;
  logic [RANKS-1:0] fill_vld_q;

  mtm_pkg::result_t res_q, res_d;
  mtm_pkg::result_t out_q;
  logic             out_valid_q;
  logic             out_load;

  logic                 slot_we;
  logic [RW+SW-1:0]     slot_waddr;
  logic [mtm_pkg::SLOT_W-1:0] slot_wdata;
  logic                 slot_re;
  logic [RW+SW-1:0]     slot_raddr;
  logic [mtm_pkg::SLOT_W-1:0] slot_rdata;
  mtm_pkg::slot_t       slot_rd;

  logic          fill_we;
  logic [FW-1:0] fill_wdata;
  logic          fill_re;
  logic [FW-1:0] fill_rdata;
  logic [FW-1:0] fill_cur;

  logic rank_ok;
  logic hit;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign rank_ext    = {{RW{1'b0}}, rank_i};

  assign rank_ok = ({1'b0, rank_q} < rank_count_q) && ({3'b000, rank_q} < RanksW);
  assign fill_cur = fill_vld_q[rank_idx_q] ? fill_rdata : '0;
  assign slot_rd  = mtm_pkg::slot_t'(slot_rdata);
  assign hit = (any_src_q || (slot_rd.src == src_q)) && (any_tag_q || (slot_rd.tag == tag_q));

  assign fill_re    = (state_q == ST_CHK);
  assign slot_re    = (state_q == ST_SCAN) && (rd_idx_q != fill_q);
  assign slot_raddr = {rank_idx_q, rd_idx_q[SW-1:0]};
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    rd_idx_d   = rd_idx_q;
    dk_d       = dk_q;
    dv_d       = 1'b0;
    found_d    = found_q;
    res_d      = res_q;
    slot_we    = 1'b0;
    slot_waddr = {rank_idx_q, dk_q - SW'(1)};
    slot_wdata = slot_rdata;
    fill_we    = 1'b0;
    fill_wdata = fill_q - FW'(1);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        res_d = '0;
        if (rank_ok) begin
          state_d = ST_FILL;
        end else begin
          res_d.status = mtm_pkg::STATUS_RANGE;
          state_d      = ST_DONE;
        end
      end
      ST_FILL: begin
        fill_d   = fill_cur;
        rd_idx_d = '0;
        found_d  = 1'b0;
        if (mode_q == mtm_pkg::MODE_RECEIVE) begin
          res_d.status = mtm_pkg::STATUS_NO_MATCH;
          state_d      = ST_SCAN;
        end else if (fill_cur >= SlotsW) begin
          res_d.status = mtm_pkg::STATUS_FULL;
          state_d      = ST_DONE;
        end else begin
          slot_we      = 1'b1;
          slot_waddr   = {rank_idx_q, fill_cur[SW-1:0]};
          slot_wdata   = {src_q, tag_q, len_q, handle_q};
          fill_we      = 1'b1;
          fill_wdata   = fill_cur + FW'(1);
          res_d.status = mtm_pkg::STATUS_QUEUED;
          state_d      = ST_DONE;
        end
      end
      ST_SCAN: begin
        if (rd_idx_q != fill_q) begin
          rd_idx_d = rd_idx_q + FW'(1);
          dk_d     = rd_idx_q[SW-1:0];
          dv_d     = 1'b1;
        end
        if (dv_q) begin
          if (found_q) begin
            slot_we = 1'b1;
          end else if (hit) begin
            found_d      = 1'b1;
            res_d.status = mtm_pkg::STATUS_MATCHED;
            res_d.src    = slot_rd.src;
            res_d.tag    = slot_rd.tag;
            res_d.len    = slot_rd.len;
            res_d.copy   = (slot_rd.len < len_q) ? slot_rd.len : len_q;
            res_d.handle = slot_rd.handle;
          end
        end else if (rd_idx_q == fill_q) begin
          fill_we = found_q;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      rank_count_q <= mtm_pkg::RANK_COUNT_RESET;
      fill_vld_q   <= '0;
      out_valid_q  <= 1'b0;
      dv_q         <= 1'b0;
      found_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      dv_q    <= dv_d;
      found_q <= found_d;
      if (cfg_valid_i) begin
        rank_count_q <= cfg_data_i;
      end
      if (fill_we) begin
        fill_vld_q[rank_idx_q] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mode_q     <= mode_i;
      rank_q     <= rank_i;
      rank_idx_q <= rank_ext[RW-1:0];
      src_q      <= source_rank_i;
      any_src_q  <= any_source_i;
      tag_q      <= msg_tag_i;
      any_tag_q  <= any_tag_i;
      len_q      <= length_i;
      handle_q   <= payload_handle_i;
    end
    fill_q   <= fill_d;
    rd_idx_q <= rd_idx_d;
    dk_q     <= dk_d;
    res_q    <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  mtm_ram #(
    .WIDTH(mtm_pkg::SLOT_W),
    .DEPTH(SLOT_DEPTH)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (slot_we),
    .waddr_i(slot_waddr),
    .wdata_i(slot_wdata),
    .re_i   (slot_re),
    .raddr_i(slot_raddr),
    .rdata_o(slot_rdata)
  );

  mtm_ram #(
    .WIDTH(FW),
    .DEPTH(FILL_DEPTH)
  ) u_fill_ram (
    .clk_i  (clk_i),
    .we_i   (fill_we),
    .waddr_i(rank_idx_q),
    .wdata_i(fill_wdata),
    .re_i   (fill_re),
    .raddr_i(rank_idx_q),
    .rdata_o(fill_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign status_code_o = out_q.status;
  assign msg_source_o  = out_q.src;
  assign msg_tag_out_o = out_q.tag;
  assign msg_length_o  = out_q.len;
  assign copy_length_o = out_q.copy;
  assign payload_out_o = out_q.handle;

  `MTM_ASSERT(a_fill_bound, fill_we |-> (fill_wdata <= SlotsW))
  `MTM_ASSERT(a_shift_after_hit, (slot_we && (state_q == ST_SCAN)) |-> found_q)
  `MTM_ASSERT(a_scan_in_fill, slot_re |-> (rd_idx_q < fill_q))
  `MTM_ASSERT(a_copy_le_len, (out_valid_q && (out_q.status == mtm_pkg::STATUS_MATCHED)) |-> (out_q.copy <= out_q.len))
  `MTM_ASSERT(a_miss_zero, (out_valid_q && (out_q.status != mtm_pkg::STATUS_MATCHED)) |-> (out_q.len == 16'd0 && out_q.handle == 16'd0))
  `MTM_ASSERT_ALWAYS(a_idle_in_reset, $rose(rst_ni) |-> (state_q == ST_IDLE))

endmodule
